// File: hdl/svcc_pkg.sv
// package for the segment view cone clipper
// shared widths, register indexes, edge side constants and the segment record type; no dependencies
package svcc_pkg;

  localparam int CW = 32;        // coordinate width, signed q16.16
  localparam int PW = 2 * CW;    // product width
  localparam int NW = 3 * CW;    // scaled numerator width
  localparam int QW = CW + 1;    // quotient bits produced by the divider
  localparam int IW = 2;         // register index width

  // register indexes
  localparam logic [IW-1:0] REG_LEFT_X  = 2'd0;
  localparam logic [IW-1:0] REG_LEFT_Y  = 2'd1;
  localparam logic [IW-1:0] REG_RIGHT_X = 2'd2;
  localparam logic [IW-1:0] REG_RIGHT_Y = 2'd3;

  // side that counts as outside for an edge
  localparam logic OUT_POSITIVE = 1'b1;
  localparam logic OUT_NEGATIVE = 1'b0;

  // one segment as it travels down the pipeline
  typedef struct packed {
    logic                 vis;
    logic                 zflag;
    logic signed [CW-1:0] ax;
    logic signed [CW-1:0] ay;
    logic signed [CW-1:0] bx;
    logic signed [CW-1:0] by;
  } seg_t;

endpackage

// File: hdl/svcc_pass.sv
// one edge clipping pass: side tests, intersection terms, scaling and division
// depends on svcc_pkg
module svcc_pass
  import svcc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 adv,
  input  logic                 reject_pos,
  input  logic signed [CW-1:0] dir_x,
  input  logic signed [CW-1:0] dir_y,
  input  logic                 in_v,
  input  seg_t                 in_seg,
  output logic                 out_v,
  output seg_t                 out_seg
);

  typedef struct packed {
    logic [PW-1:0] rem;
    logic [QW-1:0] lo;
  } dv_t;

  typedef struct packed {
    logic mv_a;
    logic mv_b;
    logic dz;
    logic negx;
    logic negy;
    logic ovx;
    logic ovy;
  } ctl_t;

  // one restoring division step
  function automatic dv_t div_step(input dv_t d, input logic [PW-1:0] dm);
    logic [PW:0] cat;
    logic        ge;
    dv_t         res;
    cat     = {d.rem, d.lo[QW-1]};
    ge      = (cat >= {1'b0, dm});
    res.rem = ge ? PW'(cat - {1'b0, dm}) : cat[PW-1:0];
    res.lo  = {d.lo[QW-2:0], ge};
    return res;
  endfunction

  // stage 1: cross products
  logic                 s1_v_r;
  seg_t                 s1_seg_r;
  logic signed [PW-1:0] m_dax_r, m_axd_r, m_dbx_r, m_bxd_r, m_ab_r, m_ba_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_seg_r <= in_seg;
      m_dax_r  <= dir_x * in_seg.ay;
      m_axd_r  <= in_seg.ax * dir_y;
      m_dbx_r  <= dir_x * in_seg.by;
      m_bxd_r  <= in_seg.bx * dir_y;
      m_ab_r   <= in_seg.ax * in_seg.by;
      m_ba_r   <= in_seg.bx * in_seg.ay;
    end
  end

  // stage 2: side values and cross(a, b)
  logic                 s2_v_r;
  seg_t                 s2_seg_r;
  logic signed [PW:0]   la_r, lb_r, cab_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (adv) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_seg_r <= s1_seg_r;
      la_r     <= {m_dax_r[PW-1], m_dax_r} - {m_axd_r[PW-1], m_axd_r};
      lb_r     <= {m_dbx_r[PW-1], m_dbx_r} - {m_bxd_r[PW-1], m_bxd_r};
      cab_r    <= {m_ab_r[PW-1], m_ab_r} - {m_ba_r[PW-1], m_ba_r};
    end
  end

  // stage 3: outside decision, divisor and signed numerator term
  logic                 out_a, out_b, s3_mv_a_nxt, s3_mv_b_nxt, rej;
  logic                 s3_v_r, s3_mv_a_r, s3_mv_b_r;
  seg_t                 s3_seg_nxt;
  seg_t                 s3_seg_r;
  logic signed [PW+1:0] d_r, cs_r;

  always_comb begin
    out_a          = reject_pos ? (la_r > 0) : (la_r < 0);
    out_b          = reject_pos ? (lb_r > 0) : (lb_r < 0);
    rej            = s2_seg_r.vis & out_a & out_b;
    s3_mv_a_nxt    = s2_seg_r.vis & out_a & ~out_b;
    s3_mv_b_nxt    = s2_seg_r.vis & out_b & ~out_a;
    s3_seg_nxt     = s2_seg_r;
    s3_seg_nxt.vis = s2_seg_r.vis & ~rej;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (adv) begin
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_seg_r     <= s3_seg_nxt;
      s3_mv_a_r    <= s3_mv_a_nxt;
      s3_mv_b_r    <= s3_mv_b_nxt;
      d_r          <= s3_mv_a_nxt ? ({lb_r[PW], lb_r} - {la_r[PW], la_r})
                                  : ({la_r[PW], la_r} - {lb_r[PW], lb_r});
      cs_r         <= s3_mv_b_nxt ? ((PW+2)'(0) - {cab_r[PW], cab_r})
                                  : {cab_r[PW], cab_r};
    end
  end

  // stage 4: magnitudes and result signs
  logic                 s4_v_r;
  seg_t                 s4_seg_r;
  ctl_t                 s4_ctl_r;
  logic [PW-1:0]        cmag_r, dmag4_r;
  logic [CW-1:0]        fxm_r, fym_r;
  logic [PW+1:0]        cmag_w, dmag_w;

  always_comb begin
    cmag_w = cs_r[PW+1] ? ((PW+2)'(0) - cs_r) : cs_r;
    dmag_w = d_r[PW+1] ? ((PW+2)'(0) - d_r) : d_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_v_r <= 1'b0;
    end else if (adv) begin
      s4_v_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_seg_r      <= s3_seg_r;
      cmag_r        <= cmag_w[PW-1:0];
      dmag4_r       <= dmag_w[PW-1:0];
      fxm_r         <= dir_x[CW-1] ? (CW'(0) - dir_x) : dir_x;
      fym_r         <= dir_y[CW-1] ? (CW'(0) - dir_y) : dir_y;
      s4_ctl_r.mv_a <= s3_mv_a_r;
      s4_ctl_r.mv_b <= s3_mv_b_r;
      s4_ctl_r.dz   <= (d_r == '0);
      s4_ctl_r.negx <= dir_x[CW-1] ^ cs_r[PW+1] ^ d_r[PW+1];
      s4_ctl_r.negy <= dir_y[CW-1] ^ cs_r[PW+1] ^ d_r[PW+1];
      s4_ctl_r.ovx  <= 1'b0;
      s4_ctl_r.ovy  <= 1'b0;
    end
  end

  // stage 5: partial products of direction times numerator
  logic                 s5_v_r;
  seg_t                 s5_seg_r;
  ctl_t                 s5_ctl_r;
  logic [PW-1:0]        dmag5_r, px0_r, px1_r, py0_r, py1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_v_r <= 1'b0;
    end else if (adv) begin
      s5_v_r <= s4_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s5_seg_r <= s4_seg_r;
      s5_ctl_r <= s4_ctl_r;
      dmag5_r  <= dmag4_r;
      px0_r    <= fxm_r * cmag_r[CW-1:0];
      px1_r    <= fxm_r * cmag_r[PW-1:CW];
      py0_r    <= fym_r * cmag_r[CW-1:0];
      py1_r    <= fym_r * cmag_r[PW-1:CW];
    end
  end

  // stage 6: full numerators
  logic                 s6_v_r;
  seg_t                 s6_seg_r;
  ctl_t                 s6_ctl_r;
  logic [PW-1:0]        dmag6_r;
  logic [NW-1:0]        nx_r, ny_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s6_v_r <= 1'b0;
    end else if (adv) begin
      s6_v_r <= s5_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s6_seg_r <= s5_seg_r;
      s6_ctl_r <= s5_ctl_r;
      dmag6_r  <= dmag5_r;
      nx_r     <= {{CW{1'b0}}, px0_r} + {px1_r, {CW{1'b0}}};
      ny_r     <= {{CW{1'b0}}, py0_r} + {py1_r, {CW{1'b0}}};
    end
  end

  // divider pipeline: entry 0 is the overflow check, then one bit per stage
  logic                 dv_v_r   [0:QW];
  seg_t                 dv_seg_r [0:QW];
  ctl_t                 dv_ctl_r [0:QW];
  logic [PW-1:0]        dv_dm_r  [0:QW];
  dv_t                  dvx_r    [0:QW];
  dv_t                  dvy_r    [0:QW];
  ctl_t                 dv_ctl_nxt;

  // quotient overflow when the high numerator part reaches the divisor
  always_comb begin
    dv_ctl_nxt     = s6_ctl_r;
    dv_ctl_nxt.ovx = ({1'b0, nx_r[NW-1:QW]} >= dmag6_r);
    dv_ctl_nxt.ovy = ({1'b0, ny_r[NW-1:QW]} >= dmag6_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_v_r[0] <= 1'b0;
    end else if (adv) begin
      dv_v_r[0] <= s6_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dv_seg_r[0]     <= s6_seg_r;
      dv_ctl_r[0]     <= dv_ctl_nxt;
      dv_dm_r[0]      <= dmag6_r;
      dvx_r[0].rem    <= {1'b0, nx_r[NW-1:QW]};
      dvx_r[0].lo     <= nx_r[QW-1:0];
      dvy_r[0].rem    <= {1'b0, ny_r[NW-1:QW]};
      dvy_r[0].lo     <= ny_r[QW-1:0];
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_div
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_v_r[k+1] <= 1'b0;
      end else if (adv) begin
        dv_v_r[k+1] <= dv_v_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dv_seg_r[k+1] <= dv_seg_r[k];
        dv_ctl_r[k+1] <= dv_ctl_r[k];
        dv_dm_r[k+1]  <= dv_dm_r[k];
        dvx_r[k+1]    <= div_step(dvx_r[k], dv_dm_r[k]);
        dvy_r[k+1]    <= div_step(dvy_r[k], dv_dm_r[k]);
      end
    end
  end

  // final stage: saturate, sign and place the moved endpoint
  logic [QW-1:0]        qx, qy;
  ctl_t                 fc;
  logic                 satx, saty;
  logic signed [CW-1:0] rxv, ryv;
  seg_t                 f_seg_nxt;
  logic                 f_v_r;
  seg_t                 f_seg_r;

  always_comb begin
    fc   = dv_ctl_r[QW];
    qx   = dvx_r[QW].lo;
    qy   = dvy_r[QW].lo;
    satx = fc.negx ? (fc.ovx | (qx > {2'b01, {(CW-1){1'b0}}}))
                   : (fc.ovx | qx[QW-1] | qx[CW-1]);
    saty = fc.negy ? (fc.ovy | (qy > {2'b01, {(CW-1){1'b0}}}))
                   : (fc.ovy | qy[QW-1] | qy[CW-1]);
    if (fc.negx) begin
      rxv = satx ? {1'b1, {(CW-1){1'b0}}} : (CW'(0) - qx[CW-1:0]);
    end else begin
      rxv = satx ? {1'b0, {(CW-1){1'b1}}} : qx[CW-1:0];
    end
    if (fc.negy) begin
      ryv = saty ? {1'b1, {(CW-1){1'b0}}} : (CW'(0) - qy[CW-1:0]);
    end else begin
      ryv = saty ? {1'b0, {(CW-1){1'b1}}} : qy[CW-1:0];
    end
    f_seg_nxt = dv_seg_r[QW];
    if ((fc.mv_a | fc.mv_b) & fc.dz) begin
      f_seg_nxt.zflag = 1'b1;
    end else if (fc.mv_a) begin
      f_seg_nxt.ax = rxv;
      f_seg_nxt.ay = ryv;
    end else if (fc.mv_b) begin
      f_seg_nxt.bx = rxv;
      f_seg_nxt.by = ryv;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_v_r <= 1'b0;
    end else if (adv) begin
      f_v_r <= dv_v_r[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f_seg_r <= f_seg_nxt;
    end
  end

  assign out_v   = f_v_r;
  assign out_seg = f_seg_r;

`ifndef SYNTHESIS
  // an endpoint move is for one endpoint at most
  a_one_move: assert property (@(posedge clk) disable iff (!rst_n)
    s3_v_r |-> $onehot0({s3_mv_a_r, s3_mv_b_r}))
    else $error("both endpoints marked for a move");

  // a rejected segment never moves an endpoint
  a_rej_still: assert property (@(posedge clk) disable iff (!rst_n)
    s3_v_r && !s3_seg_r.vis |-> !s3_mv_a_r && !s3_mv_b_r)
    else $error("rejected segment marked for a move");

  // a held pipeline keeps its last stage
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(f_v_r) && $stable(f_seg_r))
    else $error("pass output changed while held");
`endif

endmodule

// File: hdl/segment_view_cone_clip_top.sv
// segment view cone clipper, top level: registers, two clip passes, output register
// depends on svcc_pkg and svcc_pass
//
// Clips one wall segment (q16.16 endpoints relative to the viewer) against the
// view cone given by the left and right edge direction registers, left edge first.
// One request is taken every cycle while the output is not stalled; a result passes
// through the two clip passes of 41 stages each (the 33-stage bit-per-stage
// divider dominates each pass) and then through the output register. A stalled
// output holds the whole pipeline. Write the direction registers only while no
// request is in flight.
module segment_view_cone_clip_top
  import svcc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [IW-1:0]        cfg_index,
  input  logic [CW-1:0]        cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic signed [CW-1:0] in_first_x,
  input  logic signed [CW-1:0] in_first_y,
  input  logic signed [CW-1:0] in_second_x,
  input  logic signed [CW-1:0] in_second_y,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_visible,
  output logic signed [CW-1:0] out_clipped_first_x,
  output logic signed [CW-1:0] out_clipped_first_y,
  output logic signed [CW-1:0] out_clipped_second_x,
  output logic signed [CW-1:0] out_clipped_second_y,
  output logic                 out_zero_divisor
);

  logic signed [CW-1:0] left_x_r, left_y_r, right_x_r, right_y_r;
  logic                 adv;
  seg_t                 in_seg;
  logic                 p1_v, p2_v;
  seg_t                 p1_seg, p2_seg;
  logic                 out_valid_r;
  seg_t                 out_seg_nxt;
  seg_t                 out_seg_r;

  // direction registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_x_r  <= '0;
      left_y_r  <= '0;
      right_x_r <= '0;
      right_y_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LEFT_X:  left_x_r  <= cfg_wdata;
        REG_LEFT_Y:  left_y_r  <= cfg_wdata;
        REG_RIGHT_X: right_x_r <= cfg_wdata;
        REG_RIGHT_Y: right_y_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // pipeline moves unless a waiting result is stalled
  assign adv      = ~out_valid_r | ~out_stall;
  assign in_stall = ~adv;

  always_comb begin
    in_seg.vis   = 1'b1;
    in_seg.zflag = 1'b0;
    in_seg.ax    = in_first_x;
    in_seg.ay    = in_first_y;
    in_seg.bx    = in_second_x;
    in_seg.by    = in_second_y;
  end

  svcc_pass u_left (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (adv),
    .reject_pos (OUT_POSITIVE),
    .dir_x      (left_x_r),
    .dir_y      (left_y_r),
    .in_v       (in_valid),
    .in_seg     (in_seg),
    .out_v      (p1_v),
    .out_seg    (p1_seg)
  );

  svcc_pass u_right (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (adv),
    .reject_pos (OUT_NEGATIVE),
    .dir_x      (right_x_r),
    .dir_y      (right_y_r),
    .in_v       (p1_v),
    .in_seg     (p1_seg),
    .out_v      (p2_v),
    .out_seg    (p2_seg)
  );

  // output register, coordinates cleared for a rejected segment
  always_comb begin
    out_seg_nxt = p2_seg;
    if (!p2_seg.vis) begin
      out_seg_nxt.ax = '0;
      out_seg_nxt.ay = '0;
      out_seg_nxt.bx = '0;
      out_seg_nxt.by = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= p2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_seg_r <= out_seg_nxt;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_visible          = out_seg_r.vis;
  assign out_clipped_first_x  = out_seg_r.ax;
  assign out_clipped_first_y  = out_seg_r.ay;
  assign out_clipped_second_x = out_seg_r.bx;
  assign out_clipped_second_y = out_seg_r.by;
  assign out_zero_divisor     = out_seg_r.zflag;

`ifndef SYNTHESIS
  // rejected segments carry zero coordinates
  a_rej_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_visible |-> out_clipped_first_x == 0 && out_clipped_first_y == 0
      && out_clipped_second_x == 0 && out_clipped_second_y == 0)
    else $error("rejected segment with nonzero coordinates");

  // zero edge directions clip nothing
  a_zero_dir: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && left_x_r == 0 && left_y_r == 0 && right_x_r == 0 && right_y_r == 0
      |-> out_visible && !out_zero_divisor)
    else $error("segment clipped with zero edge directions");

  // input stalls only behind a waiting result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a waiting result");
`endif

endmodule

// File: bench/tb.sv
// self-checking bench for the segment view cone clipper
// depends on svcc_pkg and segment_view_cone_clip_top; predicts each clipped segment
module tb;
  import svcc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [CW-1:0] ax, ay, bx, by;
  } wall_t;

  typedef struct packed {
    logic                 vis;
    logic signed [CW-1:0] ax, ay, bx, by;
    logic                 zflag;
  } clip_t;

  localparam int LATENCY = 82;
  localparam longint LIMIT = 2000000;

  logic clk = 0, rst_n = 0;
  logic cfg_we = 0;
  logic [IW-1:0] cfg_index = REG_LEFT_X;
  logic [CW-1:0] cfg_wdata = '0;
  logic in_valid = 0, in_stall;
  logic signed [CW-1:0] in_first_x = 0, in_first_y = 0, in_second_x = 0, in_second_y = 0;
  logic out_valid, out_stall = 0, out_visible, out_zero_divisor;
  logic signed [CW-1:0] out_clipped_first_x, out_clipped_first_y;
  logic signed [CW-1:0] out_clipped_second_x, out_clipped_second_y;

  segment_view_cone_clip_top DUT (.*);

  // predictor copy of the direction registers
  logic signed [CW-1:0] edge_lx, edge_ly, edge_rx, edge_ry;

  wall_t pending_walls[$];
  clip_t expected_clips[$];
  int    errors = 0;
  int    seen_clips = 0, seen_visible = 0, seen_moved = 0;
  longint cycles = 0;
  bit    hold_sender = 0;

  initial forever #5 clk = ~clk;

  // sign of cross(dir, p)
  function automatic int side_of(logic signed [CW-1:0] dx, dy, px, py);
    logic signed [2*CW-1:0] a, b;
    a = dx * py;
    b = px * dy;
    return (a > b) ? 1 : ((a < b) ? -1 : 0);
  endfunction

  // dir coordinate scaled by c/d, truncated toward zero, saturated
  function automatic logic signed [CW-1:0] scale_to_edge(logic signed [CW-1:0] f,
      logic signed [127:0] c, logic signed [127:0] d);
    logic signed [127:0] q;
    q = (128'(f) * c) / d;
    if (q > 128'sd2147483647) return 32'h7fffffff;
    if (q < -128'sd2147483648) return 32'h80000000;
    return q[CW-1:0];
  endfunction

  // move p onto the ray dir, q being the other endpoint
  function automatic void move_onto_edge(inout logic signed [CW-1:0] px, py,
      input logic signed [CW-1:0] qx, qy, fx, fy, inout logic zf);
    logic signed [127:0] c, d;
    c = 128'(px) * 128'(qy) - 128'(qx) * 128'(py);
    d = 128'(fx) * 128'(qy) - 128'(qx) * 128'(fy) - 128'(fx) * 128'(py)
        + 128'(px) * 128'(fy);
    if (d == 0) begin
      zf = 1;
      return;
    end
    seen_moved++;
    px = scale_to_edge(fx, c, d);
    py = scale_to_edge(fy, c, d);
  endfunction

  function automatic clip_t clip_wall(wall_t w);
    clip_t r;
    int sa, sb;
    r.ax = w.ax; r.ay = w.ay; r.bx = w.bx; r.by = w.by;
    r.vis = 1; r.zflag = 0;
    sa = side_of(edge_lx, edge_ly, r.ax, r.ay);
    sb = side_of(edge_lx, edge_ly, r.bx, r.by);
    if (sa > 0 && sb > 0) r.vis = 0;
    else if (sa > 0) move_onto_edge(r.ax, r.ay, r.bx, r.by, edge_lx, edge_ly, r.zflag);
    else if (sb > 0) move_onto_edge(r.bx, r.by, r.ax, r.ay, edge_lx, edge_ly, r.zflag);
    if (r.vis) begin
      sa = side_of(edge_rx, edge_ry, r.ax, r.ay);
      sb = side_of(edge_rx, edge_ry, r.bx, r.by);
      if (sa < 0 && sb < 0) r.vis = 0;
      else if (sa < 0) move_onto_edge(r.ax, r.ay, r.bx, r.by, edge_rx, edge_ry, r.zflag);
      else if (sb < 0) move_onto_edge(r.bx, r.by, r.ax, r.ay, edge_rx, edge_ry, r.zflag);
    end
    if (!r.vis) begin
      r.ax = 0; r.ay = 0; r.bx = 0; r.by = 0;
    end
    return r;
  endfunction

  function automatic int gap_len();
    int p;
    p = $urandom_range(99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // coordinate: mostly moderate, sometimes full range or extremes
  function automatic logic [CW-1:0] rand_coord();
    int p;
    p = $urandom_range(99);
    if (p < 60) return 32'($signed($urandom_range(2000000)) - 1000000) <<< 6;
    if (p < 90) return $urandom;
    if (p < 95) return 32'h7fffffff;
    return 32'h80000000;
  endfunction

  // driver: present pending requests with random gaps
  int send_gap = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (in_valid && !in_stall) begin
      expected_clips.push_back(clip_wall(pending_walls.pop_front()));
    end
    if (!in_valid || !in_stall) begin
      if (in_valid && !in_stall && send_gap == 0 && pending_walls.size() > 0 && !hold_sender) begin
        in_valid <= 1;
        {in_first_x, in_first_y, in_second_x, in_second_y} <= pending_walls[0];
        send_gap <= gap_len();
      end else if (send_gap > 0) begin
        in_valid <= 0;
        send_gap <= send_gap - 1;
      end else if (!in_valid && pending_walls.size() > 0 && !hold_sender && rst_n) begin
        in_valid <= 1;
        {in_first_x, in_first_y, in_second_x, in_second_y} <= pending_walls[0];
        send_gap <= gap_len();
      end else begin
        in_valid <= 0;
      end
    end
  end

  // monitor: random output stalls, compare against oldest prediction
  int stall_left = 0;
  always @(posedge clk) begin
    clip_t e;
    if (out_valid && !out_stall) begin
      if (expected_clips.size() == 0) begin
        $error("result with no request outstanding");
        errors++;
      end else begin
        e = expected_clips.pop_front();
        seen_clips++;
        if (e.vis) seen_visible++;
        if (out_visible !== e.vis) begin
          $error("visible exp %0d got %0d", e.vis, out_visible); errors++;
        end
        if (out_clipped_first_x !== e.ax) begin
          $error("clipped_first_x exp %0d got %0d", e.ax, out_clipped_first_x); errors++;
        end
        if (out_clipped_first_y !== e.ay) begin
          $error("clipped_first_y exp %0d got %0d", e.ay, out_clipped_first_y); errors++;
        end
        if (out_clipped_second_x !== e.bx) begin
          $error("clipped_second_x exp %0d got %0d", e.bx, out_clipped_second_x); errors++;
        end
        if (out_clipped_second_y !== e.by) begin
          $error("clipped_second_y exp %0d got %0d", e.by, out_clipped_second_y); errors++;
        end
        if (out_zero_divisor !== e.zflag) begin
          $error("zero_divisor exp %0d got %0d", e.zflag, out_zero_divisor); errors++;
        end
      end
    end
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1;
    end else if ($urandom_range(99) < 25) begin
      stall_left <= gap_len();
      out_stall <= 1;
    end else begin
      out_stall <= 0;
    end
  end

  // timeout
  always @(posedge clk) begin
    if (cycles > LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic write_reg(logic [IW-1:0] idx, logic [CW-1:0] val);
    @(posedge clk);
    cfg_we <= 1; cfg_index <= idx; cfg_wdata <= val;
    case (idx)
      REG_LEFT_X:  edge_lx = val;
      REG_LEFT_Y:  edge_ly = val;
      REG_RIGHT_X: edge_rx = val;
      default:     edge_ry = val;
    endcase
    @(posedge clk);
    cfg_we <= 0;
  endtask

  task automatic set_cone(logic [CW-1:0] lx, ly, rx, ry);
    write_reg(REG_LEFT_X, lx);
    write_reg(REG_LEFT_Y, ly);
    write_reg(REG_RIGHT_X, rx);
    write_reg(REG_RIGHT_Y, ry);
  endtask

  task automatic drain();
    wait (pending_walls.size() == 0 && !in_valid && expected_clips.size() == 0);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  task automatic queue_wall(logic [CW-1:0] ax, ay, bx, by);
    wall_t w;
    w.ax = ax; w.ay = ay; w.bx = bx; w.by = by;
    pending_walls.push_back(w);
  endtask

  initial begin
    int phase, n;
    edge_lx = 0; edge_ly = 0; edge_rx = 0; edge_ry = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // zero directions: nothing gets clipped
    queue_wall(32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff);
    queue_wall(0, 0, 32'h00010000, 32'hffff0000);
    drain();

    // 90 degree cone looking along +y
    set_cone(32'hffff0000, 32'h00010000, 32'h00010000, 32'h00010000);
    queue_wall(32'hfff60000, 32'h00050000, 32'h000a0000, 32'h00050000); // both ends cut
    queue_wall(32'hfff60000, 32'h00010000, 32'hfff00000, 32'h00020000); // left reject
    queue_wall(32'h000a0000, 32'h00010000, 32'h00100000, 32'h00020000); // right reject
    queue_wall(32'h00000000, 32'h00050000, 32'h00010000, 32'h00060000); // fully inside
    queue_wall(32'h000a0000, 32'h00050000, 32'hfff60000, 32'h00050000); // cut, reversed
    queue_wall(32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h7fffffff);
    queue_wall(32'h80000000, 32'h80000000, 32'h7fffffff, 32'h80000000);
    queue_wall(0, 0, 0, 0);
    queue_wall(32'hffff0000, 32'h00010000, 32'h00010000, 32'h00010000); // on edges
    queue_wall(32'hffffffff, 32'h00000001, 32'h00000001, 32'hfffffffe);
    drain();

    // extreme directions, saturation likely
    set_cone(32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h80000000);
    queue_wall(32'h00000001, 32'h7fffffff, 32'h80000000, 32'h00000001);
    queue_wall(32'h7fffffff, 32'h00000001, 32'hffffffff, 32'h80000000);
    queue_wall(32'h12345678, 32'hedcba987, 32'h80000000, 32'h7fffffff);
    drain();

    // random phases with assorted cones
    for (phase = 0; phase < 6; phase++) begin
      if (phase == 5) set_cone(32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff);
      else if (phase == 0) set_cone(32'hffff0000, 32'h00010000, 32'h00010000, 32'h00010000);
      else set_cone(rand_coord(), rand_coord(), rand_coord(), rand_coord());
      for (n = 0; n < 100; n++) begin
        queue_wall(rand_coord(), rand_coord(), rand_coord(), rand_coord());
        // sender holds off once mid-phase until all results are back
        if (phase == 2 && n == 50) begin
          wait (pending_walls.size() == 0 && !in_valid);
          hold_sender = 1;
          wait (expected_clips.size() == 0);
          hold_sender = 0;
        end
      end
      drain();
    end

    $display("covered %0d segments, %0d visible, %0d endpoint moves, 9 cone settings",
             seen_clips, seen_visible, seen_moved);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule

// File: filelist.f
hdl/svcc_pkg.sv
hdl/svcc_pass.sv
hdl/segment_view_cone_clip_top.sv
bench/tb.sv
